[hdl/bsb_pkg.sv]
// Package for the B-spline basis evaluator: sequencer states, widths, constants.
// No dependencies.
`default_nettype none
package bsb_pkg;
    localparam int unsigned KNOT_W = 16;
    localparam int unsigned VAL_W  = 16;
    localparam logic [16:0] ONE_Q15 = 17'd32768;

    typedef enum logic [0:0] {
        REQ_WRITE = 1'b0,
        REQ_EVAL  = 1'b1
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BASE,
        ST_T1,
        ST_T2,
        ST_T3,
        ST_T4,
        ST_MUL,
        ST_DIV,
        ST_ACC,
        ST_STORE,
        ST_DONE
    } state_t;
endpackage
`default_nettype wire

[hdl/bsb_if.sv]
// Valid/ready channel interfaces for requests and results.
// Depends on nothing.
`default_nettype none
interface bsb_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [3:0]  knot_slot;
    logic signed [15:0] knot_value;
    logic signed [15:0] sample_x;
    logic [3:0]  basis_index;
    modport source (output valid, req_type, knot_slot, knot_value, sample_x, basis_index,
                    input ready);
    modport sink   (input valid, req_type, knot_slot, knot_value, sample_x, basis_index,
                    output ready);
endinterface

interface bsb_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] basis_value;
    logic        status;
    modport source (output valid, basis_value, status, input ready);
    modport sink   (input valid, basis_value, status, output ready);
endinterface
`default_nettype wire

[hdl/bsb_div.sv]
// Restoring signed divider, one quotient bit a cycle, truncation toward zero.
// Depends on nothing.
`default_nettype none
module bsb_div
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [33:0] dividend,
    input  wire logic signed [16:0] divisor,
    output logic                    done,
    output logic signed [33:0]      quotient
);
    logic [33:0] num_reg, num_next;
    logic [33:0] rem_reg, rem_next;
    logic [16:0] den_reg, den_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [33:0] trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done      = 1'b0;
        trial     = {rem_reg[32:0], num_reg[33]};
        if (start)
        begin
            num_next  = dividend[33] ? 34'(-dividend) : dividend;
            den_next  = divisor[16] ? 17'(-divisor) : divisor;
            neg_next  = dividend[33] ^ divisor[16];
            rem_next  = '0;
            cnt_next  = 6'd34;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {17'd0, den_reg})
            begin
                rem_next = trial - {17'd0, den_reg};
                num_next = {num_reg[32:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                num_next = {num_reg[32:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    assign quotient = neg_reg ? 34'(-$signed(num_next)) : $signed(num_next);
endmodule
`default_nettype wire

[hdl/bspline_basis_evaluator_top.sv]
// Each divided term reads its knots, multiplies and then runs the shared divider; a zero
// span skips the divider. Each base knot pair is read from the knot table. A write request
// or an out-of-range index is answered in the idle state without starting the sequencer.
// The rate is set by the shared one-bit-a-cycle divider; one request at a time.
// Reset clears control and sets degree to 3; the knot table is undefined until
// written.
`default_nettype none
module bspline_basis_evaluator_top
#(
    parameter int unsigned NUM_KNOTS  = 16,
    parameter int unsigned MAX_DEGREE = 3
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_wdata,
    bsb_req_if.sink         req,
    bsb_res_if.source       res
);
    localparam int unsigned KA = (NUM_KNOTS > 1) ? $clog2(NUM_KNOTS) : 1;
    localparam int unsigned LW = (MAX_DEGREE > 0) ? $clog2(MAX_DEGREE + 1) : 1;

    logic signed [15:0] knot_mem [NUM_KNOTS];

    bsb_pkg::state_t st_reg, st_next;
    logic [1:0]  deg_reg;
    logic [2:0]  d_eff;
    logic [2:0]  dr_reg, dr_next;
    logic [2:0]  k_reg, k_next;
    logic [2:0]  m_reg, m_next;
    logic        half_reg, half_next;
    logic [4:0]  i_reg, i_next;
    logic signed [15:0] x_reg, x_next;
    logic [16:0] lvl_reg [MAX_DEGREE + 1];
    logic signed [15:0] ta_reg, tb_reg;
    logic [KA-1:0] rd_addr;
    logic signed [15:0] rd_data_reg;
    logic signed [34:0] acc_reg, acc_next;
    logic signed [33:0] prod_reg;
    logic signed [16:0] num_reg, den_reg;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_val_reg, out_val_next;
    logic        out_st_reg, out_st_next;
    logic        div_start, div_done;
    logic signed [33:0] div_q;
    logic [2:0]  sel_a, sel_b;
    logic        load_a, load_b;
    logic        base_w;
    logic [LW-1:0] wr_idx;
    logic [16:0] wr_val;
    logic        lvl_we;

    assign d_eff = (32'(deg_reg) > MAX_DEGREE) ? 3'(MAX_DEGREE) : {1'b0, deg_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            deg_reg <= 2'd3;
        else if (cfg_we)
            deg_reg <= cfg_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready && req.req_type == bsb_pkg::REQ_WRITE &&
            32'(req.knot_slot) < NUM_KNOTS)
            knot_mem[KA'(req.knot_slot)] <= req.knot_value;
        rd_data_reg <= knot_mem[rd_addr];
    end

    bsb_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // knot address: base phase reads t[i+m], t[i+m+1]; term phase reads four knots
    always_comb
    begin
        sel_a = m_reg;
        sel_b = m_reg + 3'd1;
        if (k_reg != 3'd0)
        begin
            if (!half_reg)
            begin
                sel_a = m_reg;
                sel_b = m_reg + k_reg;
            end
            else
            begin
                sel_a = m_reg + k_reg + 3'd1;
                sel_b = m_reg + 3'd1;
            end
        end
    end

    always_comb
    begin
        st_next        = st_reg;
        dr_next        = dr_reg;
        k_next         = k_reg;
        m_next         = m_reg;
        half_next      = half_reg;
        i_next         = i_reg;
        x_next         = x_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        out_val_next   = out_val_reg;
        out_st_next    = out_st_reg;
        div_start      = 1'b0;
        load_a         = 1'b0;
        load_b         = 1'b0;
        base_w         = 1'b0;
        lvl_we         = 1'b0;
        wr_idx         = LW'(m_reg);
        wr_val         = '0;
        rd_addr        = KA'(i_reg + 5'(sel_a));
        req.ready      = 1'b0;
        if (out_valid_reg && res.ready)
            out_valid_next = 1'b0;
        unique case (st_reg)
            bsb_pkg::ST_IDLE:
            begin
                req.ready = !out_valid_reg || res.ready;
                if (req.valid && req.ready && req.req_type == bsb_pkg::REQ_EVAL)
                begin
                    i_next   = {1'b0, req.basis_index};
                    x_next   = req.sample_x;
                    dr_next  = d_eff;
                    m_next   = '0;
                    k_next   = '0;
                    half_next = 1'b0;
                    if (32'(req.basis_index) + 32'(d_eff) + 1 >= NUM_KNOTS)
                    begin
                        out_valid_next = 1'b1;
                        out_val_next   = '0;
                        out_st_next    = 1'b1;
                    end
                    else
                        st_next = bsb_pkg::ST_BASE;
                end
            end
            bsb_pkg::ST_BASE:
            begin
                rd_addr = KA'(i_reg + 5'(sel_a));
                st_next = bsb_pkg::ST_T1;
            end
            bsb_pkg::ST_T1:
            begin
                load_a  = 1'b1;
                rd_addr = KA'(i_reg + 5'(sel_b));
                st_next = bsb_pkg::ST_T2;
            end
            bsb_pkg::ST_T2:
            begin
                rd_addr = KA'(i_reg + 5'(sel_b));
                st_next = bsb_pkg::ST_T3;
            end
            bsb_pkg::ST_T3:
            begin
                load_b = 1'b1;
                if (k_reg == 3'd0)
                begin
                    base_w = 1'b1;
                    if (m_reg == dr_reg)
                    begin
                        m_next = '0;
                        k_next = 3'd1;
                        if (dr_reg == 3'd0)
                            st_next = bsb_pkg::ST_DONE;
                        else
                            st_next = bsb_pkg::ST_BASE;
                    end
                    else
                    begin
                        m_next  = m_reg + 3'd1;
                        st_next = bsb_pkg::ST_BASE;
                    end
                end
                else
                    st_next = bsb_pkg::ST_T4;
            end
            bsb_pkg::ST_T4:
            begin
                st_next = bsb_pkg::ST_MUL;
            end
            bsb_pkg::ST_MUL:
            begin
                st_next = bsb_pkg::ST_DIV;
            end
            bsb_pkg::ST_DIV:
            begin
                if (den_reg == 17'sd0)
                    st_next = bsb_pkg::ST_ACC;
                else
                begin
                    div_start = 1'b1;
                    st_next   = bsb_pkg::ST_ACC;
                end
            end
            bsb_pkg::ST_ACC:
            begin
                if (den_reg == 17'sd0 || div_done)
                begin
                    if (den_reg != 17'sd0)
                        acc_next = half_reg ? 35'(acc_reg + div_q) : 35'(div_q);
                    else if (!half_reg)
                        acc_next = '0;
                    if (!half_reg)
                    begin
                        half_next = 1'b1;
                        st_next   = bsb_pkg::ST_BASE;
                    end
                    else
                        st_next = bsb_pkg::ST_STORE;
                end
            end
            bsb_pkg::ST_STORE:
            begin
                lvl_we    = 1'b1;
                wr_val    = acc_reg[34] ? 17'd0 :
                            (acc_reg > $signed({1'b0, bsb_pkg::ONE_Q15})) ?
                            bsb_pkg::ONE_Q15 : acc_reg[16:0];
                half_next = 1'b0;
                if (m_reg + k_reg == dr_reg)
                begin
                    m_next = '0;
                    if (k_reg == dr_reg)
                        st_next = bsb_pkg::ST_DONE;
                    else
                    begin
                        k_next  = k_reg + 3'd1;
                        st_next = bsb_pkg::ST_BASE;
                    end
                end
                else
                begin
                    m_next  = m_reg + 3'd1;
                    st_next = bsb_pkg::ST_BASE;
                end
            end
            bsb_pkg::ST_DONE:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = lvl_reg[0][15:0];
                    out_st_next    = 1'b0;
                    st_next        = bsb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                st_next = bsb_pkg::ST_IDLE;
            end
        endcase
    end

    // term datapath: ta = first knot, tb = second knot; numerator/denominator
    always_ff @(posedge clk)
    begin
        if (load_a)
            ta_reg <= rd_data_reg;
        if (load_b)
            tb_reg <= rd_data_reg;
        if (st_reg == bsb_pkg::ST_T4)
        begin
            if (!half_reg)
            begin
                num_reg <= 17'(x_reg) - 17'(ta_reg);
                den_reg <= 17'(tb_reg) - 17'(ta_reg);
            end
            else
            begin
                num_reg <= 17'(ta_reg) - 17'(x_reg);
                den_reg <= 17'(ta_reg) - 17'(tb_reg);
            end
        end
        if (st_reg == bsb_pkg::ST_MUL)
            prod_reg <= num_reg * $signed({1'b0, lvl_reg[LW'(m_reg + 3'(half_reg))]});
        if (base_w)
            lvl_reg[LW'(m_reg)] <= (ta_reg <= x_reg && x_reg < rd_data_reg) ?
                                   bsb_pkg::ONE_Q15 : 17'd0;
        if (lvl_we)
            lvl_reg[wr_idx] <= wr_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= bsb_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            dr_reg <= '0;
            k_reg  <= '0;
            m_reg  <= '0;
            half_reg <= 1'b0;
            i_reg  <= '0;
        end
        else
        begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
            dr_reg <= dr_next;
            k_reg  <= k_next;
            m_reg  <= m_next;
            half_reg <= half_next;
            i_reg  <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        acc_reg     <= acc_next;
        out_val_reg <= out_val_next;
        out_st_reg  <= out_st_next;
    end

    assign res.valid       = out_valid_reg;
    assign res.basis_value = out_val_reg;
    assign res.status      = out_st_reg;

    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != bsb_pkg::ST_IDLE) |-> !req.ready)
        else $error("request taken while busy");
    a_val_range: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.basis_value <= 16'd32768))
        else $error("basis value above one");
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.status) |-> (res.basis_value == 16'd0))
        else $error("out of range result not zero");
endmodule
`default_nettype wire

[tb/tb_bspline_basis_evaluator_top.sv]
// Self-checking testbench for the B-spline basis evaluator: knot writes and basis
// evaluations over valid/ready channels, compared against a behavioral predictor.
// Depends on bsb_pkg, bsb_if and bspline_basis_evaluator_top.
`default_nettype none

class basis_scoreboard;
    logic signed [15:0] knots [16];
    bit                 knot_set [16];
    logic [1:0]         degree;
    logic [15:0]        exp_value [$];
    logic               exp_status [$];
    int                 errors;
    int                 checked;
    int                 oob_seen;

    function new();
        degree = 2'd3;
        errors = 0;
        checked = 0;
        oob_seen = 0;
        foreach (knot_set[n]) knot_set[n] = 1'b0;
    endfunction

    function longint clamp_q15(longint v);
        if (v < 0) return 0;
        if (v > 32768) return 32768;
        return v;
    endfunction

    function longint term(longint num, longint den, longint n);
        if (den == 0) return 0;
        return (num * n) / den;
    endfunction

    function void note_request(logic rtype, logic [3:0] slot, logic signed [15:0] kv,
                               logic signed [15:0] x, logic [3:0] idx);
        int unsigned d;
        longint lvl [5];
        longint xs;
        longint tj, tjk, tj1, tjk1;
        if (rtype == bsb_pkg::REQ_WRITE)
        begin
            knots[slot] = kv;
            knot_set[slot] = 1'b1;
            return;
        end
        d = degree;
        if (idx + d + 1 >= 16)
        begin
            exp_value.push_back(16'd0);
            exp_status.push_back(1'b1);
            oob_seen++;
            return;
        end
        xs = x;
        for (int m = 0; m <= d; m++)
        begin
            tj = knots[idx + m];
            tj1 = knots[idx + m + 1];
            lvl[m] = (tj <= xs && xs < tj1) ? 32768 : 0;
        end
        for (int k = 1; k <= d; k++)
        begin
            for (int m = 0; m + k <= d; m++)
            begin
                tj = knots[idx + m];
                tjk = knots[idx + m + k];
                tj1 = knots[idx + m + 1];
                tjk1 = knots[idx + m + k + 1];
                lvl[m] = clamp_q15(term(xs - tj, tjk - tj, lvl[m])
                                   + term(tjk1 - xs, tjk1 - tj1, lvl[m + 1]));
            end
        end
        exp_value.push_back(lvl[0][15:0]);
        exp_status.push_back(1'b0);
    endfunction

    task report(string msg);
        $display("ERROR: %s", msg);
        errors++;
    endtask

    task check_result(logic [15:0] value, logic status);
        logic [15:0] ev;
        logic        es;
        checked++;
        if (exp_value.size() == 0)
        begin
            report($sformatf("unexpected result value=%0d status=%0d", value, status));
            return;
        end
        ev = exp_value.pop_front();
        es = exp_status.pop_front();
        if (value !== ev)
            report($sformatf("result %0d basis_value got %0d want %0d", checked, value, ev));
        if (status !== es)
            report($sformatf("result %0d status got %0d want %0d", checked, status, es));
    endtask
endclass

module tb_bspline_basis_evaluator_top;
    localparam int IDLE_LIMIT = 20000;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_wdata;
    logic       allow_gaps;
    logic       hold_off;
    logic       hold_done;
    int         idle_cycles;
    int         evals_sent;

    bsb_req_if req ();
    bsb_res_if res ();

    basis_scoreboard sb;

    bspline_basis_evaluator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req.sink),
        .res       (res.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic send_request(logic rtype, logic [3:0] slot, logic signed [15:0] kv,
                                logic signed [15:0] x, logic [3:0] idx);
        int gap;
        if (allow_gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid       <= 1'b1;
        req.req_type    <= rtype;
        req.knot_slot   <= slot;
        req.knot_value  <= kv;
        req.sample_x    <= x;
        req.basis_index <= idx;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        sb.note_request(rtype, slot, kv, x, idx);
        if (rtype == bsb_pkg::REQ_EVAL) evals_sent++;
        @(negedge clk);
    endtask

    task automatic write_knot(int slot, int kv);
        send_request(bsb_pkg::REQ_WRITE, slot[3:0], kv[15:0], 16'sd0, 4'd0);
    endtask

    task automatic evaluate(int x, int idx);
        send_request(bsb_pkg::REQ_EVAL, 4'd0, 16'($urandom()), x[15:0], idx[3:0]);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (sb.exp_value.size() != 0) @(negedge clk);
        repeat (600) @(negedge clk);
    endtask

    task automatic set_degree(int d);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= d[1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.degree = d[1:0];
    endtask

    task automatic load_sorted_knots(int spacing_max);
        int v;
        v = $urandom_range(0, 1) ? -32768 + $urandom_range(0, 2000)
                                 : $urandom_range(0, 4000) - 2000;
        for (int s = 0; s < 16; s++)
        begin
            write_knot(s, v);
            if ($urandom_range(0, 5) != 0) v = v + $urandom_range(0, spacing_max);
            if (v > 32767) v = 32767;
        end
    endtask

    task automatic random_knot_sample(int idx);
        int lo;
        int hi;
        lo = $signed(sb.knots[idx]);
        hi = $signed(sb.knots[idx + sb.degree + 1]);
        if (lo > hi)
        begin
            lo = $signed(sb.knots[idx + sb.degree + 1]);
            hi = $signed(sb.knots[idx]);
        end
        case ($urandom_range(0, 7))
            0: evaluate($urandom(), idx);
            1: evaluate(lo, idx);
            2: evaluate(hi, idx);
            default: evaluate(lo + $urandom_range(0, hi - lo), idx);
        endcase
    endtask

    task automatic random_phase(int count);
        int idx;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(0, 19))
                0: write_knot($urandom_range(0, 15), $urandom());
                1: write_knot($urandom_range(0, 15), $urandom_range(0, 1) ? 32767 : -32768);
                2: evaluate($urandom(), $urandom_range(0, 15));
                3: load_sorted_knots($urandom_range(0, 3000));
                default:
                begin
                    idx = $urandom_range(0, 15 - sb.degree - 1);
                    random_knot_sample(idx);
                end
            endcase
        end
    endtask

    initial
    begin
        res.ready = 1'b1;
        hold_done = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_off && !hold_done)
            begin
                res.ready <= 1'b0;
                repeat (3000) @(negedge clk);
                hold_done = 1'b1;
                res.ready <= 1'b1;
            end
            else if (allow_gaps && $urandom_range(0, 5) == 0)
            begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(negedge clk);
            end
            else
            begin
                res.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready) sb.check_result(res.basis_value, res.status);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (res.valid && res.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        evals_sent = 0;
        allow_gaps = 1'b0;
        hold_off = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 2'd3;
        req.valid = 1'b0;
        req.req_type = bsb_pkg::REQ_WRITE;
        req.knot_slot = 4'd0;
        req.knot_value = 16'sd0;
        req.sample_x = 16'sd0;
        req.basis_index = 4'd0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int s = 0; s < 16; s++) write_knot(s, (s - 8) * 256);
        evaluate(0, 4);
        evaluate(-512, 5);
        evaluate(32767, 0);
        evaluate(-32768, 0);
        evaluate(0, 12);
        evaluate(0, 15);
        write_knot(6, 0);
        write_knot(7, 0);
        evaluate(0, 5);
        evaluate(0, 6);
        write_knot(9, -1024);
        evaluate(100, 7);
        write_knot(0, 32767);
        write_knot(1, -32768);
        evaluate(0, 0);
        evaluate(32767, 0);

        for (int d = 0; d < 4; d++)
        begin
            set_degree(d);
            evaluate(0, 15 - d);
            evaluate(0, 14 - d);
            allow_gaps = 1'b1;
            load_sorted_knots(1500);
            random_phase(150);
        end

        hold_off = 1'b1;
        set_degree(1);
        load_sorted_knots(800);
        random_phase(40);
        set_degree($urandom_range(0, 1) ? 3 : 0);
        allow_gaps = 1'b0;
        random_phase(300);
        set_degree(2);
        random_phase(60);
        drain();

        $display("Covered degrees 0..3, sorted, repeated and unordered knots, index overflow,");
        $display("%0d evaluations checked with random stalls and a long result hold-off.",
                 sb.checked);
        if (sb.errors == 0 && sb.exp_value.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

`default_nettype wire

[sim.f]
hdl/bsb_pkg.sv
hdl/bsb_if.sv
hdl/bsb_div.sv
hdl/bspline_basis_evaluator_top.sv
tb/tb_bspline_basis_evaluator_top.sv
